/* src/pba_pkg.sv */
// Shared types and constants for the pooled bitmap block allocator.
// No dependencies; used by the interfaces, the order list, the top level and the checker.
package pba_pkg;

  localparam int POOL_SLOTS = 8;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int POOL_BITS  = 32;
  localparam int IDX_W      = $clog2(POOL_BITS);
  localparam int COUNT_W    = $clog2(POOL_SLOTS + 1);
  localparam int ESIZE_W    = 13;
  localparam int OFFSET_W   = 20;
  localparam int STATUS_W   = 2;

  localparam logic [ESIZE_W-1:0] ESIZE_RESET = 13'd16;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SLOT  = 2'd1,
    STATUS_NOT_LIVE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PLAN,
    S_MODIFY,
    S_FINISH
  } state_t;

  // What the modify step does with the bitmap
  typedef enum logic [1:0] {
    PLAN_NONE,
    PLAN_HIT,
    PLAN_NEW,
    PLAN_FREE
  } plan_t;

  // Result of the order-list scan
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              spare;
    logic [SLOT_W-1:0] spare_slot;
  } scan_t;

  // Update command into the order list
  typedef struct packed {
    logic              add;
    logic              drop;
    logic              full_we;
    logic              full_val;
    logic [SLOT_W-1:0] slot;
  } ord_upd_t;

  function automatic logic [IDX_W-1:0] lowest_zero(input logic [POOL_BITS-1:0] v);
    logic [IDX_W-1:0] n;
    n = '0;
    for (int i = POOL_BITS - 1; i >= 0; i--) begin
      if (!v[i]) n = IDX_W'(i);
    end
    return n;
  endfunction

endpackage

/* src/pba_if.sv */
// Valid/ready channel interfaces: request, response and element-size write.
// Depends on pba_pkg for field widths and the status type.
interface pba_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [pba_pkg::SLOT_W-1:0] pool_slot;
  logic [pba_pkg::IDX_W-1:0]  element_index;

  modport source (output valid, operation, pool_slot, element_index, input ready);
  modport sink   (input valid, operation, pool_slot, element_index, output ready);
endinterface

interface pba_rsp_if;
  logic                         valid;
  logic                         ready;
  pba_pkg::status_t             status;
  logic [pba_pkg::SLOT_W-1:0]   given_slot;
  logic [pba_pkg::IDX_W-1:0]    given_index;
  logic [pba_pkg::OFFSET_W-1:0] byte_offset;
  logic                         pool_released;

  modport source (output valid, status, given_slot, given_index, byte_offset, pool_released,
                  input ready);
  modport sink   (input valid, status, given_slot, given_index, byte_offset, pool_released,
                  output ready);
endinterface

interface pba_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pba_pkg::ESIZE_W-1:0] element_size;

  modport source (output valid, element_size, input ready);
  modport sink   (input valid, element_size, output ready);
endinterface

/* src/pba_order_list.sv */
// Pool order list: live slots in creation order, live and full flags per slot.
// Depends on pba_pkg. Scans for the first non-full live pool and a spare slot.
module pba_order_list (
  input  logic                       clk,
  input  logic                       rst,
  input  pba_pkg::ord_upd_t          upd,
  input  logic [pba_pkg::SLOT_W-1:0] query_slot,
  output logic                       query_live,
  output pba_pkg::scan_t             scan
);
  import pba_pkg::*;

  logic [SLOT_W-1:0]  order [POOL_SLOTS];
  logic [SLOT_W-1:0]  order_next [POOL_SLOTS];
  logic [COUNT_W-1:0] count;
  logic [POOL_SLOTS-1:0] live;
  logic [POOL_SLOTS-1:0] full;
  logic [POOL_SLOTS-1:0] shift;

  assign query_live = live[query_slot];

  always_comb begin
    scan = '0;
    for (int k = POOL_SLOTS - 1; k >= 0; k--) begin
      if (COUNT_W'(k) < count && !full[order[k]]) begin
        scan.hit      = 1'b1;
        scan.hit_slot = order[k];
      end
      if (!live[k]) begin
        scan.spare      = 1'b1;
        scan.spare_slot = SLOT_W'(k);
      end
    end
  end

  // Removal: every entry from the released slot onward takes its successor
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int k = 0; k < POOL_SLOTS; k++) begin
      if (COUNT_W'(k) < count && order[k] == upd.slot) seen = 1'b1;
      shift[k] = seen;
    end
    for (int k = 0; k < POOL_SLOTS; k++) begin
      if (k < POOL_SLOTS - 1 && shift[k]) order_next[k] = order[(k + 1) % POOL_SLOTS];
      else order_next[k] = order[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      live  <= '0;
      full  <= '0;
    end else begin
      if (upd.full_we) full[upd.slot] <= upd.full_val;
      if (upd.add) begin
        live[upd.slot] <= 1'b1;
        count          <= count + COUNT_W'(1);
      end else if (upd.drop) begin
        live[upd.slot] <= 1'b0;
        count          <= count - COUNT_W'(1);
      end
    end
  end

  // Order entries past count are never looked at, so they carry no reset
  always_ff @(posedge clk) begin
    if (upd.add) begin
      order[count[SLOT_W-1:0]] <= upd.slot;
    end else if (upd.drop) begin
      for (int k = 0; k < POOL_SLOTS; k++) order[k] <= order_next[k];
    end
  end

endmodule

/* src/pooled_bitmap_block_allocator.sv */
// Top level of the pooled bitmap block allocator: sequencer, bitmap memory,
// offset multiplier and result register. Depends on pba_pkg, pba_if, pba_order_list.
//
// Each request passes through one state per step: accept, plan (order-list scan
// and bitmap read issue), modify (lowest free bit or clear, write-back, order
// update) and finish ((slot*32+index)*element_size). The result register loads
// in the finish state once any earlier result has been taken, and the next
// request can transfer in the idle state that follows. The bitmap memory read is
// registered; requests are handled one at a time, so no two memory accesses to
// the same pool overlap. A new request is taken while a result still waits in
// the output register; the finish step holds until that result has been taken.
// No clearing pass after reset: a pool's bitmap is written when the pool is
// created and never read before. The user must write element_size only while no
// request is in flight, since the finish step uses its current value; the block
// does not enforce this. Both input channels hold ready low during reset.
module pooled_bitmap_block_allocator (
  input  logic           clk,
  input  logic           rst,
  pba_req_if.sink        req,
  pba_rsp_if.source      rsp,
  pba_cfg_if.sink        cfg
);
  import pba_pkg::*;

  state_t state, state_next;

  logic [ESIZE_W-1:0] element_size;

  // Accepted request
  op_t              cur_op;
  logic [SLOT_W-1:0] cur_slot;
  logic [IDX_W-1:0]  cur_idx;

  // Plan registers
  plan_t             plan;
  logic [SLOT_W-1:0] plan_slot;
  status_t           plan_status;

  // Modify results
  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [IDX_W-1:0]  res_idx;
  logic              res_released;

  // Bitmap memory
  logic [POOL_BITS-1:0] occ_mem [POOL_SLOTS];
  logic [POOL_BITS-1:0] occ_rdata;
  logic                 mem_re;
  logic                 mem_we;
  logic [POOL_BITS-1:0] new_word;
  logic [IDX_W-1:0]     free_bit;

  ord_upd_t upd;
  scan_t    scan;
  logic     query_live;

  logic     in_xfer;
  logic     out_load;
  logic [SLOT_W+IDX_W+ESIZE_W-1:0] product;

  plan_t             plan_d;
  logic [SLOT_W-1:0] plan_slot_d;
  status_t           plan_status_d;

  pba_order_list u_order (
    .clk        (clk),
    .rst        (rst),
    .upd        (upd),
    .query_slot (cur_slot),
    .query_live (query_live),
    .scan       (scan)
  );

  assign cfg.ready = !rst;
  assign in_xfer   = req.valid && req.ready;
  assign out_load  = (state == S_FINISH) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) element_size <= ESIZE_RESET;
    else if (cfg.valid && cfg.ready) element_size <= cfg.element_size;
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_xfer) state_next = S_PLAN;
      S_PLAN:   state_next = S_MODIFY;
      S_MODIFY: state_next = S_FINISH;
      S_FINISH: if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    unique case (state)
      S_IDLE:   req.ready = !rst;
      S_PLAN:   mem_re    = (plan_d == PLAN_HIT) || (plan_d == PLAN_FREE);
      S_MODIFY: mem_we    = (plan != PLAN_NONE);
      S_FINISH: ;
      default:  ;
    endcase
  end

  // ---------------- plan ----------------
  always_comb begin
    plan_d        = PLAN_NONE;
    plan_slot_d   = cur_slot;
    plan_status_d = STATUS_OK;
    if (cur_op == OP_ALLOC) begin
      if (scan.hit) begin
        plan_d      = PLAN_HIT;
        plan_slot_d = scan.hit_slot;
      end else if (scan.spare) begin
        plan_d      = PLAN_NEW;
        plan_slot_d = scan.spare_slot;
      end else begin
        plan_status_d = STATUS_NO_SLOT;
      end
    end else if (query_live) begin
      plan_d = PLAN_FREE;
    end else begin
      plan_status_d = STATUS_NOT_LIVE;
    end
  end

  // ---------------- modify ----------------
  assign free_bit = lowest_zero(occ_rdata);

  always_comb begin
    new_word = occ_rdata;
    case (plan)
      PLAN_HIT:  new_word = occ_rdata | (POOL_BITS'(1) << free_bit);
      PLAN_NEW:  new_word = POOL_BITS'(1);
      PLAN_FREE: new_word = occ_rdata & ~(POOL_BITS'(1) << cur_idx);
      default:   new_word = occ_rdata;
    endcase
  end

  always_comb begin
    upd          = '0;
    upd.slot     = plan_slot;
    if (state == S_MODIFY && plan != PLAN_NONE) begin
      upd.full_we  = 1'b1;
      upd.full_val = &new_word;
      upd.add      = (plan == PLAN_NEW);
      upd.drop     = (plan == PLAN_FREE) && (new_word == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) occ_mem[plan_slot] <= new_word;
    if (mem_re) occ_rdata <= occ_mem[plan_slot_d];
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_op   <= op_t'(req.operation);
      cur_slot <= req.pool_slot;
      cur_idx  <= req.element_index;
    end
    if (state == S_PLAN) begin
      plan        <= plan_d;
      plan_slot   <= plan_slot_d;
      plan_status <= plan_status_d;
    end
    if (state == S_MODIFY) begin
      res_status   <= plan_status;
      res_released <= upd.drop;
      res_slot     <= '0;
      res_idx      <= '0;
      if (plan == PLAN_HIT || plan == PLAN_NEW) res_slot <= plan_slot;
      if (plan == PLAN_HIT) res_idx <= free_bit;
    end
  end

  // Errors and frees carry slot and index zero, so the product is zero too
  assign product = {res_slot, res_idx} * element_size;

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status        <= res_status;
      rsp.given_slot    <= res_slot;
      rsp.given_index   <= res_idx;
      rsp.byte_offset   <= product[OFFSET_W-1:0];
      rsp.pool_released <= res_released;
    end
  end

endmodule

/* src/pba_checker.sv */
// Port-level checks for the pooled bitmap block allocator, and their bind.
// Depends on pba_pkg; attaches to pooled_bitmap_block_allocator.
module pba_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input pba_pkg::status_t             status,
  input logic [pba_pkg::SLOT_W-1:0]   given_slot,
  input logic [pba_pkg::IDX_W-1:0]    given_index,
  input logic [pba_pkg::OFFSET_W-1:0] byte_offset,
  input logic                         pool_released
);
  import pba_pkg::*;

  // One request in flight: the channel closes right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  // An error result carries nothing else
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STATUS_OK |->
      given_slot == '0 && given_index == '0 && byte_offset == '0 && !pool_released)
    else $error("error result with nonzero fields");

  // A release only comes from a successful free, which gives no element
  a_release_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && pool_released |->
      status == STATUS_OK && given_slot == '0 && given_index == '0 && byte_offset == '0)
    else $error("release result with element fields");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(byte_offset))
    else $error("result changed while stalled");

endmodule

bind pooled_bitmap_block_allocator pba_checker u_pba_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .given_slot    (rsp.given_slot),
  .given_index   (rsp.given_index),
  .byte_offset   (rsp.byte_offset),
  .pool_released (rsp.pool_released)
);
